[design/sha256de_pkg.sv]
// Shared types and constants for the SHA-256 digest engine.
// No dependencies; imported by sha256de_ctrl, sha256de_dp and the top level.

package sha256de_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MODE_MSG,
        MODE_PAD,
        MODE_FINAL
    } mode_t;

    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_MARK,
        BSEL_ZERO,
        BSEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic       shift_byte;
        byte_sel_t  byte_sel;
        logic       count_len;
        logic       load_vars;
        logic       round;
        logic [5:0] round_idx;
        logic       update;
        logic       restart;
        logic [2:0] word_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_at_55;
        logic fill_at_63;
    } dp_status_t;

    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] v;
        case (idx)
            6'd0:    v = 32'h428a2f98;
            6'd1:    v = 32'h71374491;
            6'd2:    v = 32'hb5c0fbcf;
            6'd3:    v = 32'he9b5dba5;
            6'd4:    v = 32'h3956c25b;
            6'd5:    v = 32'h59f111f1;
            6'd6:    v = 32'h923f82a4;
            6'd7:    v = 32'hab1c5ed5;
            6'd8:    v = 32'hd807aa98;
            6'd9:    v = 32'h12835b01;
            6'd10:   v = 32'h243185be;
            6'd11:   v = 32'h550c7dc3;
            6'd12:   v = 32'h72be5d74;
            6'd13:   v = 32'h80deb1fe;
            6'd14:   v = 32'h9bdc06a7;
            6'd15:   v = 32'hc19bf174;
            6'd16:   v = 32'he49b69c1;
            6'd17:   v = 32'hefbe4786;
            6'd18:   v = 32'h0fc19dc6;
            6'd19:   v = 32'h240ca1cc;
            6'd20:   v = 32'h2de92c6f;
            6'd21:   v = 32'h4a7484aa;
            6'd22:   v = 32'h5cb0a9dc;
            6'd23:   v = 32'h76f988da;
            6'd24:   v = 32'h983e5152;
            6'd25:   v = 32'ha831c66d;
            6'd26:   v = 32'hb00327c8;
            6'd27:   v = 32'hbf597fc7;
            6'd28:   v = 32'hc6e00bf3;
            6'd29:   v = 32'hd5a79147;
            6'd30:   v = 32'h06ca6351;
            6'd31:   v = 32'h14292967;
            6'd32:   v = 32'h27b70a85;
            6'd33:   v = 32'h2e1b2138;
            6'd34:   v = 32'h4d2c6dfc;
            6'd35:   v = 32'h53380d13;
            6'd36:   v = 32'h650a7354;
            6'd37:   v = 32'h766a0abb;
            6'd38:   v = 32'h81c2c92e;
            6'd39:   v = 32'h92722c85;
            6'd40:   v = 32'ha2bfe8a1;
            6'd41:   v = 32'ha81a664b;
            6'd42:   v = 32'hc24b8b70;
            6'd43:   v = 32'hc76c51a3;
            6'd44:   v = 32'hd192e819;
            6'd45:   v = 32'hd6990624;
            6'd46:   v = 32'hf40e3585;
            6'd47:   v = 32'h106aa070;
            6'd48:   v = 32'h19a4c116;
            6'd49:   v = 32'h1e376c08;
            6'd50:   v = 32'h2748774c;
            6'd51:   v = 32'h34b0bcb5;
            6'd52:   v = 32'h391c0cb3;
            6'd53:   v = 32'h4ed8aa4a;
            6'd54:   v = 32'h5b9cca4f;
            6'd55:   v = 32'h682e6ff3;
            6'd56:   v = 32'h748f82ee;
            6'd57:   v = 32'h78a5636f;
            6'd58:   v = 32'h84c87814;
            6'd59:   v = 32'h8cc70208;
            6'd60:   v = 32'h90befffa;
            6'd61:   v = 32'ha4506ceb;
            6'd62:   v = 32'hbef9a3f7;
            default: v = 32'hc67178f2;
        endcase
        return v;
    endfunction

endpackage

[design/sha256de_ctrl.sv]
// Sequencer for the SHA-256 digest engine: input, padding, rounds, digest out.
// Depends on sha256de_pkg; drives sha256de_dp through dp_cmd_t.

module sha256de_ctrl
    import sha256de_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       byte_present,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] word_index,
    output logic       last_word,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t     state_reg, state_next;
    mode_t      mode_reg, mode_next;
    logic       mark_reg, mark_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] widx_reg, widx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_MSG;
            mark_reg  <= 1'b0;
            rnd_reg   <= '0;
            widx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            mark_reg  <= mark_next;
            rnd_reg   <= rnd_next;
            widx_reg  <= widx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        mark_next  = mark_reg;
        rnd_next   = rnd_reg;
        widx_next  = widx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_present && status.fill_at_63)
                    begin
                        state_next = ST_LOAD;
                        mode_next  = end_of_message ? MODE_PAD : MODE_MSG;
                        mark_next  = 1'b1;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                        mode_next  = MODE_PAD;
                        mark_next  = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                mark_next = 1'b0;
                if (status.fill_at_63)
                begin
                    state_next = ST_LOAD;
                end
                else if (status.fill_at_55)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (status.fill_at_63)
                begin
                    state_next = ST_LOAD;
                    mode_next  = MODE_FINAL;
                end
            end
            ST_LOAD:
            begin
                rnd_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                widx_next = '0;
                case (mode_reg)
                    MODE_PAD:   state_next = ST_PAD;
                    MODE_FINAL: state_next = ST_OUT;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                        mode_next  = MODE_MSG;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall       = 1'b1;
        out_valid      = 1'b0;
        cmd            = '0;
        cmd.byte_sel   = BSEL_DATA;
        cmd.round_idx  = rnd_reg;
        cmd.word_idx   = widx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.shift_byte = in_valid && byte_present;
                cmd.count_len  = in_valid && byte_present;
            end
            ST_PAD:
            begin
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = mark_reg ? BSEL_MARK : BSEL_ZERO;
            end
            ST_LEN:
            begin
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = BSEL_LEN;
            end
            ST_LOAD:
            begin
                cmd.load_vars = 1'b1;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ST_OUT:
            begin
                out_valid   = 1'b1;
                cmd.restart = !out_stall && (widx_reg == 3'd7);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign word_index = widx_reg;
    assign last_word  = (widx_reg == 3'd7);

endmodule

[design/sha256de_dp.sv]
// Datapath of the SHA-256 digest engine: block shift register (doubles as the
// schedule window), round logic, hash words, length and fill counters.
// Depends on sha256de_pkg; driven by sha256de_ctrl.

module sha256de_dp
    import sha256de_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic [31:0] digest_word
);

    logic [511:0] msg_reg;
    logic [31:0]  vars_reg [8];
    logic [31:0]  hash_reg [8];
    logic [63:0]  bitlen_reg;
    logic [5:0]   fill_reg;

    logic [7:0]   byte_in;
    logic [7:0]   len_byte;
    logic [31:0]  w_cur;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    // length bytes go out most significant first at fill positions 56..63
    assign len_byte = 8'(bitlen_reg >> {~fill_reg[2:0], 3'b000});

    always_comb
    begin
        case (cmd.byte_sel)
            BSEL_MARK: byte_in = PAD_MARK;
            BSEL_ZERO: byte_in = 8'h00;
            BSEL_LEN:  byte_in = len_byte;
            default:   byte_in = data_byte;
        endcase
    end

    // window word j sits at msg_reg[511-32j -: 32]
    assign w_cur = msg_reg[511:480];
    assign w_new = sig1(msg_reg[63:32]) + msg_reg[223:192]
                 + sig0(msg_reg[479:448]) + w_cur;

    assign t1 = vars_reg[7] + bsig1(vars_reg[4])
              + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
              + round_k(cmd.round_idx) + w_cur;
    assign t2 = bsig0(vars_reg[0])
              + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                 ^ (vars_reg[1] & vars_reg[2]));

    always_ff @(posedge clk)
    begin
        if (cmd.shift_byte)
        begin
            msg_reg <= {msg_reg[503:0], byte_in};
        end
        else if (cmd.round)
        begin
            msg_reg <= {msg_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_vars)
        begin
            for (int i = 0; i < 8; i++)
            begin
                vars_reg[i] <= hash_reg[i];
            end
        end
        else if (cmd.round)
        begin
            vars_reg[7] <= vars_reg[6];
            vars_reg[6] <= vars_reg[5];
            vars_reg[5] <= vars_reg[4];
            vars_reg[4] <= vars_reg[3] + t1;
            vars_reg[3] <= vars_reg[2];
            vars_reg[2] <= vars_reg[1];
            vars_reg[1] <= vars_reg[0];
            vars_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= init_hash(3'(i));
            end
            bitlen_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= init_hash(3'(i));
                end
                bitlen_reg <= '0;
            end
            else
            begin
                if (cmd.update)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + vars_reg[i];
                    end
                end
                if (cmd.count_len)
                begin
                    bitlen_reg <= bitlen_reg + 64'd8;
                end
            end
            if (cmd.shift_byte)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
        end
    end

    assign status.fill_at_55 = (fill_reg == 6'd55);
    assign status.fill_at_63 = (fill_reg == 6'd63);
    assign digest_word       = hash_reg[cmd.word_idx];

endmodule

[design/sha256_digest_engine.sv]
// SHA-256 digest engine, top level.
//
// Input channel (in_valid / in_stall): one item per accepted edge carrying
// data_byte, byte_present and end_of_message. An item with byte_present low
// and end_of_message low is taken and has no effect. end_of_message closes the
// message (its byte, if present, belongs to the message) and an empty message
// is allowed.
// Output channel (out_valid / out_stall): eight items per message, digest
// words 0..7 with word_index and last_word set on word 7.
// Timing: each 64th byte starts a compression of the block (load, 64 rounds at
// one round per cycle through the single round unit, hash update). Closing a
// message shifts in padding and length one byte per cycle up to the end of
// the block (plus one more block when 56 or more bytes are pending), runs a
// compression, then offers the eight words, one per cycle when not stalled.
// in_stall is high whenever the engine is padding, compressing or emitting.
// A stalled output word holds; the engine simply waits.
// Reset loads the initial hash values and clears length and fill count;
// after word 7 is taken the same state is restored for the next message.
// Depends on sha256de_pkg, sha256de_ctrl and sha256de_dp.

module sha256_digest_engine
    import sha256de_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sha256de_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .word_index     (word_index),
        .last_word      (last_word),
        .status         (status),
        .cmd            (cmd)
    );

    sha256de_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .status      (status),
        .digest_word (digest_word)
    );

endmodule
